FILE: src/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the source line classifier and counter.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int NUM_TYPES = 5;
    localparam int TYPE_W    = 3;
    localparam int CNT_W     = 26;
    localparam int TOT_W     = 28;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(50000000);

    // both queues
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_SLASH,
        PFX_COMMENT,
        PFX_CODE
    } pfx_t;

    typedef enum logic [1:0] {
        CLS_BLANK   = 2'd0,
        CLS_COMMENT = 2'd1,
        CLS_CODE    = 2'd2
    } line_class_t;

    // one classified beat handed from front to back
    typedef struct packed {
        logic              line_done;
        line_class_t       line_class;
        logic              file_done;
        logic [TYPE_W-1:0] lang_sel;
    } op_t;

    typedef struct packed {
        logic              line_done;
        line_class_t       line_class;
        logic              file_done;
        logic [CNT_W-1:0]  code_count;
        logic [CNT_W-1:0]  blank_count;
        logic [CNT_W-1:0]  comment_count;
        logic [TOT_W-1:0]  all_lines_count;
        logic [CNT_W-1:0]  files_count;
    } res_t;

endpackage

FILE: src/slc_front.sv
// ----------------------------------------------------------------------------
// slc_front
// Tracks the line prefix and classes each line as it ends.
// ----------------------------------------------------------------------------
module slc_front
    import slc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              kind,
    input  logic [TYPE_W-1:0] lang_sel,
    input  logic [7:0]        data_byte,
    output op_t               op
);

    pfx_t        pfx_reg, pfx_next;
    logic        pending_reg, pending_next;
    line_class_t cls;

    always_comb
    begin
        case (pfx_reg)
            PFX_NONE:    cls = CLS_BLANK;
            PFX_COMMENT: cls = CLS_COMMENT;
            default:     cls = CLS_CODE;
        endcase
    end

    always_comb
    begin
        pfx_next       = pfx_reg;
        pending_next   = pending_reg;
        op.line_done   = 1'b0;
        op.line_class  = CLS_BLANK;
        op.file_done   = 1'b0;
        op.lang_sel    = lang_sel;
        if (kind == KIND_EOF)
        begin
            op.line_done  = pending_reg;
            op.line_class = pending_reg ? cls : CLS_BLANK;
            op.file_done  = 1'b1;
            pfx_next      = PFX_NONE;
            pending_next  = 1'b0;
        end
        else if (data_byte == CHAR_LF)
        begin
            op.line_done  = 1'b1;
            op.line_class = cls;
            pfx_next      = PFX_NONE;
            pending_next  = 1'b0;
        end
        else
        begin
            pending_next = 1'b1;
            if (data_byte != CHAR_CR)
            begin
                case (pfx_reg)
                    PFX_NONE:
                    begin
                        if (data_byte == CHAR_STAR)
                            pfx_next = PFX_COMMENT;
                        else if (data_byte == CHAR_SLASH)
                            pfx_next = PFX_SLASH;
                        else if (!(data_byte inside {CHAR_SPACE, CHAR_TAB}))
                            pfx_next = PFX_CODE;
                    end
                    PFX_SLASH:
                    begin
                        pfx_next = (data_byte inside {CHAR_SLASH, CHAR_STAR})
                                   ? PFX_COMMENT : PFX_CODE;
                    end
                    default:
                    begin
                        pfx_next = pfx_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfx_reg     <= PFX_NONE;
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pfx_reg     <= pfx_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: src/slc_op_queue.sv
// ----------------------------------------------------------------------------
// slc_op_queue
// Short queue of classified beats between the front and the counter back.
// ----------------------------------------------------------------------------
module slc_op_queue
    import slc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wr_op,
    output logic full,
    input  logic rd_en,
    output op_t  rd_op,
    output logic empty
);

    op_t            entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: src/slc_back.sv
// ----------------------------------------------------------------------------
// slc_back
// Per-type counter rows, the limit register and the result queue.
// ----------------------------------------------------------------------------
module slc_back
    import slc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             op_empty,
    input  op_t              op,
    output logic             op_rd,
    input  logic             pop,
    output logic             empty,
    output res_t             res
);

    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] code_reg    [NUM_TYPES];
    logic [CNT_W-1:0] blank_reg   [NUM_TYPES];
    logic [CNT_W-1:0] comment_reg [NUM_TYPES];
    logic [TOT_W-1:0] total_reg   [NUM_TYPES];
    logic [CNT_W-1:0] files_reg   [NUM_TYPES];

    res_t             rq_reg [QDEPTH];
    logic [QAW-1:0]   rq_wr_reg;
    logic [QAW-1:0]   rq_rd_reg;
    logic [QAW:0]     rq_cnt_reg, rq_cnt_next;

    logic             type_ok;
    logic [TYPE_W-1:0] idx;
    logic [CNT_W-1:0] code_cur, blank_cur, comment_cur, files_cur, line_cur;
    logic [TOT_W-1:0] total_cur;
    logic             line_inc, file_inc;
    logic [CNT_W-1:0] code_new, blank_new, comment_new, files_new;
    logic [TOT_W-1:0] total_new;
    logic             popping;
    res_t             res_new;

    assign popping = pop && !empty;
    assign op_rd   = !op_empty && (rq_cnt_reg != (QAW+1)'(QDEPTH));
    assign empty   = (rq_cnt_reg == '0);
    assign res     = rq_reg[rq_rd_reg];

    assign type_ok = (32'(op.lang_sel) < NUM_TYPES);
    assign idx     = type_ok ? op.lang_sel : '0;

    assign code_cur    = code_reg[idx];
    assign blank_cur   = blank_reg[idx];
    assign comment_cur = comment_reg[idx];
    assign total_cur   = total_reg[idx];
    assign files_cur   = files_reg[idx];

    always_comb
    begin
        case (op.line_class)
            CLS_BLANK:   line_cur = blank_cur;
            CLS_COMMENT: line_cur = comment_cur;
            default:     line_cur = code_cur;
        endcase
    end

    assign line_inc = op.line_done && type_ok && (line_cur < limit_reg);
    assign file_inc = op.file_done && type_ok && (files_cur < limit_reg);

    always_comb
    begin
        code_new    = code_cur;
        blank_new   = blank_cur;
        comment_new = comment_cur;
        total_new   = total_cur;
        files_new   = files_cur;
        if (line_inc)
        begin
            total_new = total_cur + 1'b1;
            case (op.line_class)
                CLS_BLANK:   blank_new   = blank_cur + 1'b1;
                CLS_COMMENT: comment_new = comment_cur + 1'b1;
                default:     code_new    = code_cur + 1'b1;
            endcase
        end
        if (file_inc)
            files_new = files_cur + 1'b1;
    end

    always_comb
    begin
        res_new.line_done       = op.line_done;
        res_new.line_class      = op.line_class;
        res_new.file_done       = op.file_done;
        res_new.code_count      = type_ok ? code_new    : '0;
        res_new.blank_count     = type_ok ? blank_new   : '0;
        res_new.comment_count   = type_ok ? comment_new : '0;
        res_new.all_lines_count = type_ok ? total_new   : '0;
        res_new.files_count     = type_ok ? files_new   : '0;
    end

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (op_rd && !popping)
            rq_cnt_next = rq_cnt_reg + 1'b1;
        else if (!op_rd && popping)
            rq_cnt_next = rq_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (op_rd)
            rq_reg[rq_wr_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                code_reg[i]    <= '0;
                blank_reg[i]   <= '0;
                comment_reg[i] <= '0;
                total_reg[i]   <= '0;
                files_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            // write back the updated row of this beat's type
            if (op_rd && type_ok)
            begin
                code_reg[idx]    <= code_new;
                blank_reg[idx]   <= blank_new;
                comment_reg[idx] <= comment_new;
                total_reg[idx]   <= total_new;
                files_reg[idx]   <= files_new;
            end
            if (op_rd)
                rq_wr_reg <= rq_wr_reg + 1'b1;
            if (popping)
                rq_rd_reg <= rq_rd_reg + 1'b1;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

endmodule

FILE: src/source_line_classifier_counter.sv
// Path: a pushed beat is held in the op queue and its result in the result
// queue until popped. Throughput: one beat per cycle while the receiver keeps
// popping, one row updated per beat; both queues are two entries deep.
// Reset: rst_n clears the line state, all counters and both queues at once,
// and loads the count limit with 50000000.
// ----------------------------------------------------------------------------
// source_line_classifier_counter
// Classes source lines as blank, comment or code and keeps per-type counts.
// ----------------------------------------------------------------------------
module source_line_classifier_counter
    import slc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              kind,
    input  logic [TYPE_W-1:0] lang_sel,
    input  logic [7:0]        data_byte,
    output logic              empty,
    input  logic              pop,
    output logic              line_done,
    output logic [1:0]        line_class,
    output logic              file_done,
    output logic [CNT_W-1:0]  code_count,
    output logic [CNT_W-1:0]  blank_count,
    output logic [CNT_W-1:0]  comment_count,
    output logic [TOT_W-1:0]  all_lines_count,
    output logic [CNT_W-1:0]  files_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data
);

    logic accept;
    op_t  front_op;
    op_t  back_op;
    logic op_empty;
    logic op_rd;
    res_t res;

    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    slc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .lang_sel  (lang_sel),
        .data_byte (data_byte),
        .op        (front_op)
    );

    slc_op_queue u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (accept),
        .wr_op (front_op),
        .full  (full),
        .rd_en (op_rd),
        .rd_op (back_op),
        .empty (op_empty)
    );

    slc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .op_empty  (op_empty),
        .op        (back_op),
        .op_rd     (op_rd),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign line_done       = res.line_done;
    assign line_class      = res.line_class;
    assign file_done       = res.file_done;
    assign code_count      = res.code_count;
    assign blank_count     = res.blank_count;
    assign comment_count   = res.comment_count;
    assign all_lines_count = res.all_lines_count;
    assign files_count     = res.files_count;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte and end-of-file beats into the source line classifier and
// counter under random sender bursts and receiver stalls. A scoreboard keeps
// its own copy of the line state and the per-type counters and checks every
// popped beat field by field. The count limit is stepped through zero, one,
// small saturating values and the top of its range between phases.
// ----------------------------------------------------------------------------
module testbench;
    import slc_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 205;
    localparam int NUM_PHASES   = 6;

    localparam logic [TYPE_W-1:0] FT_JAVA   = 3'd0;
    localparam logic [TYPE_W-1:0] FT_C      = 3'd1;
    localparam logic [TYPE_W-1:0] FT_CPP    = 3'd2;
    localparam logic [TYPE_W-1:0] FT_HEADER = 3'd3;
    localparam logic [TYPE_W-1:0] FT_CSHARP = 3'd4;
    localparam logic [TYPE_W-1:0] FT_TOP    = 3'd7;

    typedef enum int {BYTE_GAP, BYTE_CODE, BYTE_BODY} byte_sort_t;

    // ------------------------------------------------------------------------
    // Line and counter tally: predicts one result beat per input beat.
    // ------------------------------------------------------------------------
    class line_tally;
        logic [CNT_W-1:0] cap;
        logic             pending;
        pfx_t             prefix;
        logic [CNT_W-1:0] code_n    [NUM_TYPES];
        logic [CNT_W-1:0] blank_n   [NUM_TYPES];
        logic [CNT_W-1:0] comment_n [NUM_TYPES];
        logic [TOT_W-1:0] total_n   [NUM_TYPES];
        logic [CNT_W-1:0] files_n   [NUM_TYPES];
        res_t             expected_rows[$];
        int               errors;

        function new();
            cap     = LIMIT_RESET;
            pending = 1'b0;
            prefix  = PFX_NONE;
            errors  = 0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                code_n[i]    = '0;
                blank_n[i]   = '0;
                comment_n[i] = '0;
                total_n[i]   = '0;
                files_n[i]   = '0;
            end
        endfunction

        function int waiting();
            return expected_rows.size();
        endfunction

        function void set_cap(logic [CNT_W-1:0] v);
            cap = v;
        endfunction

        // class the open line, count it against ft and start a fresh line
        function line_class_t close_line(logic [TYPE_W-1:0] ft);
            line_class_t cls;
            if (prefix == PFX_NONE)
                cls = CLS_BLANK;
            else if (prefix == PFX_COMMENT)
                cls = CLS_COMMENT;
            else
                cls = CLS_CODE;
            if (ft < NUM_TYPES)
            begin
                // the total advances only together with the class counter
                case (cls)
                    CLS_BLANK:
                    begin
                        if (blank_n[ft] < cap)
                        begin
                            blank_n[ft] = blank_n[ft] + 1'b1;
                            total_n[ft] = total_n[ft] + 1'b1;
                        end
                    end
                    CLS_COMMENT:
                    begin
                        if (comment_n[ft] < cap)
                        begin
                            comment_n[ft] = comment_n[ft] + 1'b1;
                            total_n[ft]   = total_n[ft] + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (code_n[ft] < cap)
                        begin
                            code_n[ft]  = code_n[ft] + 1'b1;
                            total_n[ft] = total_n[ft] + 1'b1;
                        end
                    end
                endcase
            end
            pending = 1'b0;
            prefix  = PFX_NONE;
            return cls;
        endfunction

        function void absorb_item(logic k, logic [TYPE_W-1:0] ft, logic [7:0] b);
            res_t row;
            row = '0;
            if (k == KIND_EOF)
            begin
                if (pending)
                begin
                    row.line_done  = 1'b1;
                    row.line_class = close_line(ft);
                end
                row.file_done = 1'b1;
                if (ft < NUM_TYPES && files_n[ft] < cap)
                    files_n[ft] = files_n[ft] + 1'b1;
                pending = 1'b0;
                prefix  = PFX_NONE;
            end
            else if (b == CHAR_LF)
            begin
                row.line_done  = 1'b1;
                row.line_class = close_line(ft);
            end
            else
            begin
                pending = 1'b1;
                if (b != CHAR_CR)
                begin
                    case (prefix)
                        PFX_NONE:
                        begin
                            if (b == CHAR_STAR)
                                prefix = PFX_COMMENT;
                            else if (b == CHAR_SLASH)
                                prefix = PFX_SLASH;
                            else if (b != CHAR_SPACE && b != CHAR_TAB)
                                prefix = PFX_CODE;
                        end
                        PFX_SLASH:
                        begin
                            if (b == CHAR_SLASH || b == CHAR_STAR)
                                prefix = PFX_COMMENT;
                            else
                                prefix = PFX_CODE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            if (ft < NUM_TYPES)
            begin
                row.code_count      = code_n[ft];
                row.blank_count     = blank_n[ft];
                row.comment_count   = comment_n[ft];
                row.all_lines_count = total_n[ft];
                row.files_count     = files_n[ft];
            end
            expected_rows.push_back(row);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_row(res_t got);
            res_t want;
            if (expected_rows.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            match_field("line_done", want.line_done, got.line_done);
            match_field("line_class", want.line_class, got.line_class);
            match_field("file_done", want.file_done, got.file_done);
            match_field("code_count", want.code_count, got.code_count);
            match_field("blank_count", want.blank_count, got.blank_count);
            match_field("comment_count", want.comment_count, got.comment_count);
            match_field("all_lines_count", want.all_lines_count, got.all_lines_count);
            match_field("files_count", want.files_count, got.files_count);
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic              kind      = 1'b0;
    logic [TYPE_W-1:0] lang_sel  = '0;
    logic [7:0]        data_byte = '0;
    logic              pop       = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CNT_W-1:0]  cfg_data  = '0;
    logic              full;
    logic              empty;
    logic              line_done;
    logic [1:0]        line_class;
    logic              file_done;
    logic [CNT_W-1:0]  code_count;
    logic [CNT_W-1:0]  blank_count;
    logic [CNT_W-1:0]  comment_count;
    logic [TOT_W-1:0]  all_lines_count;
    logic [CNT_W-1:0]  files_count;
    logic              cfg_ready;

    line_tally board;
    int        burst_left   = 0;
    int        items_sent   = 0;
    int        quiet_cycles = 0;
    int        stall_mode   = 0;
    int        stall_left   = 0;

    source_line_classifier_counter u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .lang_sel        (lang_sel),
        .data_byte       (data_byte),
        .empty           (empty),
        .pop             (pop),
        .line_done       (line_done),
        .line_class      (line_class),
        .file_done       (file_done),
        .code_count      (code_count),
        .blank_count     (blank_count),
        .comment_count   (comment_count),
        .all_lines_count (all_lines_count),
        .files_count     (files_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // observe every handshake before the block's own updates land
    always @(posedge clk)
    begin
        res_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_cap(cfg_data);
            if (push && !full)
                board.absorb_item(kind, lang_sel, data_byte);
            if (pop && !empty)
            begin
                seen.line_done       = line_done;
                seen.line_class      = line_class_t'(line_class);
                seen.file_done       = file_done;
                seen.code_count      = code_count;
                seen.blank_count     = blank_count;
                seen.comment_count   = comment_count;
                seen.all_lines_count = all_lines_count;
                seen.files_count     = files_count;
                board.check_row(seen);
            end
        end
    end

    // receiver: switch between free flow, coin flips and long stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        if (stall_mode == 0)
            pop <= 1'b1;
        else if (stall_mode == 1)
            pop <= 1'($urandom_range(0, 1));
        else
            pop <= ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[source_line_classifier_counter] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [7:0] random_byte(byte_sort_t sort);
        logic [7:0] b;
        if (sort == BYTE_GAP)
        begin
            case ($urandom_range(0, 2))
                0: b = CHAR_SPACE;
                1: b = CHAR_TAB;
                default: b = CHAR_CR;
            endcase
        end
        else if (sort == BYTE_CODE)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b inside {CHAR_LF, CHAR_CR, CHAR_SPACE, CHAR_TAB, CHAR_SLASH, CHAR_STAR});
        end
        else
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CHAR_LF);
        end
        return b;
    endfunction

    // push one beat; leaves push high so back-to-back beats need no gap
    task automatic send_item(input logic k, input logic [TYPE_W-1:0] ft, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        push      <= 1'b1;
        kind      <= k;
        lang_sel  <= ft;
        data_byte <= b;
        do
            @(posedge clk);
        while (!(push && !full));
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic [TYPE_W-1:0] ft);
        for (int i = 0; i < s.len(); i++)
            send_item(KIND_DATA, ft, s[i]);
    endtask

    // hold the sender until every expected beat has been popped
    task automatic drain();
        push <= 1'b0;
        // let the scoreboard take in the last accepted beat first
        @(posedge clk);
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_cap(input logic [CNT_W-1:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // one file of mostly well-formed lines, with some raw noise lines
    task automatic gen_file();
        logic [TYPE_W-1:0] ft;
        logic [TYPE_W-1:0] end_ft;
        logic [7:0]        b;
        int                n_lines;
        int                count;
        ft = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(NUM_TYPES, 7))
                                         : TYPE_W'($urandom_range(0, 4));
        n_lines = $urandom_range(1, 8);
        for (int ln = 0; ln < n_lines; ln++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                count = $urandom_range(1, 10);
                repeat (count)
                begin
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 7) == 0)
                        b = CHAR_LF;
                    send_item(KIND_DATA, ft, b);
                end
                continue;
            end
            count = $urandom_range(0, 3);
            repeat (count) send_item(KIND_DATA, ft, random_byte(BYTE_GAP));
            case ($urandom_range(0, 7))
                1: send_text("//", ft);
                2: send_text("/*", ft);
                3: send_text("*", ft);
                4:
                begin
                    send_item(KIND_DATA, ft, CHAR_SLASH);
                    send_item(KIND_DATA, ft, random_byte(BYTE_CODE));
                end
                5: send_item(KIND_DATA, ft, CHAR_SLASH);
                6: send_item(KIND_DATA, ft, random_byte(BYTE_CODE));
                7:
                begin
                    // a dropped CR between the two comment characters
                    send_item(KIND_DATA, ft, CHAR_SLASH);
                    send_item(KIND_DATA, ft, CHAR_CR);
                    send_item(KIND_DATA, ft, $urandom_range(0, 1) ? CHAR_SLASH : CHAR_STAR);
                end
                default:
                begin
                end
            endcase
            count = $urandom_range(0, 6);
            repeat (count) send_item(KIND_DATA, ft, random_byte(BYTE_BODY));
            // leave the last line open now and then so end of file closes it
            if (ln == n_lines - 1 && $urandom_range(0, 1) == 0)
                break;
            end_ft = ($urandom_range(0, 14) == 0) ? TYPE_W'($urandom_range(0, 7)) : ft;
            send_item(KIND_DATA, end_ft, CHAR_LF);
        end
        end_ft = ($urandom_range(0, 14) == 0) ? TYPE_W'($urandom_range(0, 7)) : ft;
        send_item(KIND_EOF, end_ft, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [CNT_W-1:0] caps [NUM_PHASES];
        int               target;
        board = new();
        caps[0] = 26'd1;
        caps[1] = '0;
        caps[2] = CNT_W'($urandom_range(8, 30));
        caps[3] = CNT_W'($urandom_range(31, 80));
        caps[4] = '1;
        caps[5] = LIMIT_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines under the reset limit
        send_text("\n", FT_JAVA);
        send_text(" \t\r\n", FT_C);
        send_text("//\n", FT_CPP);
        send_text("/*\n", FT_HEADER);
        send_text("*\n", FT_CSHARP);
        send_text("/\n", FT_JAVA);
        send_item(KIND_DATA, FT_C, 8'h00);
        send_item(KIND_DATA, FT_C, CHAR_LF);
        send_item(KIND_DATA, FT_CPP, "x");
        send_item(KIND_EOF, FT_HEADER, 8'hFF);
        send_item(KIND_EOF, FT_HEADER, 8'h00);
        send_item(KIND_DATA, FT_CSHARP, CHAR_CR);
        send_item(KIND_EOF, FT_CSHARP, 8'h00);
        send_item(KIND_DATA, FT_TOP, 8'hFF);
        send_item(KIND_DATA, FT_TOP, CHAR_LF);
        send_item(KIND_EOF, TYPE_W'(NUM_TYPES), 8'h00);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_cap(caps[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                gen_file();
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.waiting() == 0)
            $display("[source_line_classifier_counter] OK");
        else
            $display("[source_line_classifier_counter] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/slc_pkg.sv
src/slc_front.sv
src/slc_op_queue.sv
src/slc_back.sv
src/source_line_classifier_counter.sv
dv/testbench.sv
